[src/xkps_pkg.sv]
// ----------------------------------------------------------------------------
// xkps_pkg
// Shared constants and types for the XOR keyed pattern scanner.
// ----------------------------------------------------------------------------
package xkps_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int OFFSET_BITS = 32;
	localparam int WORD_W      = 64;
	localparam int LEN_W       = 5;
	localparam int IDX_W       = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} reg_idx_t;

	typedef logic [MAX_PATTERN-1:0][7:0] pat_row_t;
	typedef logic [LEN_W-1:0]            len_t;
	typedef logic [OFFSET_BITS-1:0]      count_t;

	// aligned pattern as seen by the cell row
	typedef struct packed {
		pat_row_t                 pat;
		logic [MAX_PATTERN-1:0]   active;
		len_t                     len;
	} cfg_view_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

[src/xkps_cfg.sv]
// ----------------------------------------------------------------------------
// xkps_cfg
// Configuration registers and per-cell pattern alignment.
// ----------------------------------------------------------------------------
module xkps_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [xkps_pkg::IDX_W-1:0]  wr_index,
	input  logic [xkps_pkg::WORD_W-1:0] wr_data,
	output xkps_pkg::cfg_view_t      view
);
	import xkps_pkg::*;

	logic [WORD_W-1:0] pattern_low_q;
	logic [WORD_W-1:0] pattern_high_q;
	len_t              pattern_length_q;
	len_t              len_used;
	pat_row_t          pat_all;
	logic [3:0]        j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PATTERN_LOW:    pattern_low_q    <= wr_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= wr_data;
				REG_PATTERN_LENGTH: pattern_length_q <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pattern_length_q == '0)
			len_used = LEN_W'(1);
		else if (pattern_length_q > LEN_W'(MAX_PATTERN))
			len_used = LEN_W'(MAX_PATTERN);
		else
			len_used = pattern_length_q;
	end

	assign pat_all = {pattern_high_q, pattern_low_q};

	// cell i holds window entry i, which lines up with pattern byte len-1-i
	always_comb begin
		view.len = len_used;
		j = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			j = 4'(len_used - LEN_W'(1) - LEN_W'(i));
			view.active[i] = (LEN_W'(i) < len_used);
			view.pat[i]    = pat_all[j];
		end
	end

endmodule

[src/xkps_cell.sv]
// ----------------------------------------------------------------------------
// xkps_cell
// One window byte: shifts in from its neighbor and checks its XOR key.
// ----------------------------------------------------------------------------
module xkps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  xkps_pkg::cell_ctl_t ctl,
	input  logic [7:0]          data_in,
	input  logic [7:0]          pat_byte,
	input  logic                active,
	input  logic [7:0]          key,
	output logic [7:0]          data_out,
	output logic                eq
);
	import xkps_pkg::*;

	logic [7:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctl.shift) begin
			data_q <= ctl.clear ? 8'h00 : data_in;
		end
	end

	// compare on the value this cell takes with the incoming item
	assign eq       = !active || ((data_in ^ pat_byte) == key);
	assign data_out = data_q;

endmodule

[src/xor_keyed_pattern_scan.sv]
// ----------------------------------------------------------------------------
// xor_keyed_pattern_scan
// Sliding-window search for a pattern under any single-byte XOR key.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    data_byte, end_of_file
//  output    out_valid / out_ready  match_offset, xor_key
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per cycle; a result appears in the cycle after its item, from the
//  output register. The row of 16 byte cells checks all window positions at
//  once, so the rate is set by the output register alone. in_ready drops only
//  while a result waits and out_ready is low. Reset clears the window, count
//  and out_valid, presets config at once; no sweep. cfg_ready is always high.
// ----------------------------------------------------------------------------
module xor_keyed_pattern_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             end_of_file,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [xkps_pkg::OFFSET_BITS-1:0] match_offset,
	output logic [7:0]                       xor_key,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [xkps_pkg::IDX_W-1:0]       cfg_index,
	input  logic [xkps_pkg::WORD_W-1:0]      cfg_data
);
	import xkps_pkg::*;

	cfg_view_t              view;
	cell_ctl_t              ctl;
	logic                   accept;
	logic [7:0]             key;
	logic [MAX_PATTERN:0][7:0] link;
	logic [MAX_PATTERN-1:0] eq;
	count_t                 count_q;
	count_t                 count_next;
	logic                   check;
	logic                   hit;
	logic                   out_valid_q;
	count_t                 match_offset_q;
	logic [7:0]             xor_key_q;

	assign cfg_ready = 1'b1;

	xkps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.view     (view)
	);

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign ctl.shift = accept;
	assign ctl.clear = end_of_file;

	// newest byte against the last used pattern byte gives the only candidate
	assign key     = data_byte ^ view.pat[0];
	assign link[0] = data_byte;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		xkps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.data_in  (link[i]),
			.pat_byte (view.pat[i]),
			.active   (view.active[i]),
			.key      (key),
			.data_out (link[i+1]),
			.eq       (eq[i])
		);
	end

	assign count_next = (count_q == {OFFSET_BITS{1'b1}}) ? count_q : count_q + count_t'(1);
	assign check      = count_next >= OFFSET_BITS'(view.len);
	assign hit        = check && (&eq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= end_of_file ? '0 : count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= hit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			match_offset_q <= count_next - OFFSET_BITS'(view.len);
			xor_key_q      <= key;
		end
	end

	assign out_valid    = out_valid_q;
	assign match_offset = match_offset_q;
	assign xor_key      = xor_key_q;

	a_eof_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_file |=> count_q == '0)
		else $error("byte count not restarted after last item of file");

	a_eof_window: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_file |=> link[MAX_PATTERN:1] == '0)
		else $error("window not cleared after last item of file");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !end_of_file |=> count_q != '0)
		else $error("byte count zero after a mid-file item");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(accept))
		else $error("result raised without an accepted item");

endmodule
